// ===== rtl/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared sizes, the front-to-back job word and the pipelined square root steps.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight);
    localparam int PixW       = 24;
    localparam int SqW        = 21;
    // The partial root carries the trial bit, so it spans the full square.
    localparam int RootW      = SqW;

    // Configuration register indexes.
    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    // One 3x3 window column pair result, handed from front to back.
    typedef struct packed {
        logic [2:0][2:0][PixW-1:0] win;
        logic                      last;
    } t_job;

    // Signed gradient sum of one channel, range -1020..1020.
    typedef logic signed [11:0] t_grad;

    // Square root partial state.
    typedef struct packed {
        logic [SqW-1:0]   rem;
        logic [RootW-1:0] res;
    } t_root;

    // One digit-pair step of the bitwise square root.
    function automatic t_root root_step(t_root s, logic [SqW:0] bit_val);
        t_root o;
        logic [SqW+1:0] trial;
        trial = {2'b0, s.rem} - ({2'b0, s.res} + {1'b0, bit_val});
        o = s;
        if (!trial[SqW+1]) begin
            o.rem = trial[SqW-1:0];
            o.res = RootW'(({1'b0, s.res} >> 1) + bit_val);
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/sobel_rgb_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// Sobel RGB edge magnitude
// 3x3 Sobel gradient magnitude per color channel on a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on i_valid / o_stall as red, green and blue bytes in raster
// order. For each pixel at row >= 2 and column >= 2 one word leaves on
// o_valid / i_stall with the saturated magnitudes of the window centered
// one row up and one column left; o_last_of_frame marks the frame's last one.
// From an accepted pixel to its word the path runs through the stage 1
// line-store read, the window, the squares, the sum, eleven root stages,
// the result queue and the output register.
// Border pixels pass at one per cycle while credits remain; words are
// credited against a 16-deep queue that paces interior pixels with no stalls.
// When the receiver stalls, words collect in the queue and o_stall rises
// once the credits run out; the root pipeline itself never halts.
// Writes on the config channel (index 0 width, 1 height) are taken every
// cycle and restart the frame at row 0, column 0. Reset sets 640 by 480 and
// empties the pipeline; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
module sobel_rgb_edge_magnitude (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_last_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [10:0]                    r_width;
    logic [12:0]                    r_height;
    logic [sobel_pkg::ColW:0]       width_c;
    logic [sobel_pkg::RowW:0]       height_c;
    logic                           cfg_we;
    logic                           job_valid;
    logic                           job_room;
    sobel_pkg::t_job                job;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 13'd480;
        end else if (cfg_we) begin
            case (i_cfg_index)
                sobel_pkg::CfgWidth:  r_width  <= i_cfg_data[10:0];
                sobel_pkg::CfgHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to the supported frame size.
    always_comb begin
        if (r_width < 11'd3) begin
            width_c = 11'd3;
        end else if (r_width > 11'(sobel_pkg::MaxWidth)) begin
            width_c = 11'(sobel_pkg::MaxWidth);
        end else begin
            width_c = r_width;
        end
        if (r_height < 13'd3) begin
            height_c = 13'd3;
        end else if (r_height > 13'(sobel_pkg::MaxHeight)) begin
            height_c = 13'(sobel_pkg::MaxHeight);
        end else begin
            height_c = r_height;
        end
    end

    sobel_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_we),
        .i_width     (width_c),
        .i_height    (height_c),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_room  (job_room)
    );

    sobel_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_job_room      (job_room),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== rtl/sobel_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sobel_front.sv =====
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, keeps line stores and the window, emits interior windows.
// ----------------------------------------------------------------------------
module sobel_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic [sobel_pkg::ColW:0]   i_width,
    input  logic [sobel_pkg::RowW:0]   i_height,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_red,
    input  logic [7:0]                 i_green,
    input  logic [7:0]                 i_blue,
    output logic                       o_job_valid,
    output sobel_pkg::t_job            o_job,
    input  logic                       i_job_room
);

    // Stage 1 holds the accepted pixel while the line stores are read.
    logic                           r_s1_valid;
    logic [sobel_pkg::PixW-1:0]     r_s1_px;
    logic [sobel_pkg::ColW-1:0]     r_s1_col;
    logic                           r_s1_emit;
    logic                           r_s1_last;
    logic [sobel_pkg::ColW-1:0]     r_col, n_col;
    logic [sobel_pkg::RowW-1:0]     r_row, n_row;
    logic [2:0][2:0][sobel_pkg::PixW-1:0] r_win;
    logic                           r_job_valid;
    logic                           r_job_last;
    logic [sobel_pkg::PixW-1:0]     up_q, mid_q;
    logic                           accept;
    logic                           end_col, end_row;

    // Stall only when the queue has no room for a result in flight.
    assign o_stall = !i_job_room;
    assign accept  = i_valid && !o_stall;

    assign end_col = ({1'b0, r_col} + 1'b1) >= i_width;
    assign end_row = ({1'b0, r_row} + 1'b1) >= i_height;

    // Raster position update.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (end_col) begin
                n_col = '0;
                n_row = end_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores: read on accept, written in the following cycle from stage 1.
    sobel_ram #(.Width(sobel_pkg::PixW), .Depth(sobel_pkg::MaxWidth)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (mid_q),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (up_q)
    );

    sobel_ram #(.Width(sobel_pkg::PixW), .Depth(sobel_pkg::MaxWidth)) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (mid_q)
    );

    // Stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px   <= {i_red, i_green, i_blue};
            r_s1_col  <= r_col;
            r_s1_emit <= (r_row >= sobel_pkg::RowW'(2)) && (r_col >= sobel_pkg::ColW'(2));
            r_s1_last <= end_col && end_row;
        end
    end

    // Window shift; a read of a column just written in the previous
    // cycle cannot occur since consecutive pixels differ in column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= up_q;
            r_win[1][2] <= mid_q;
            r_win[2][2] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else begin
            r_job_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_job_last <= r_s1_last;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job.win   = r_win;
    assign o_job.last  = r_job_last;

endmodule

// ===== rtl/sobel_back.sv =====
// ----------------------------------------------------------------------------
// Sobel back end
// Queue, gradient sums, pipelined square root and output register.
// ----------------------------------------------------------------------------
module sobel_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  sobel_pkg::t_job i_job,
    output logic            o_job_room,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic            o_last_of_frame
);

    localparam int QDepth = 16;
    localparam int QW     = $clog2(QDepth);
    // Words that may be in flight in front and pipeline beyond the queue.
    localparam int Slack  = 3;
    localparam int Steps  = 11;
    localparam int Pipe   = Steps + 2;
    localparam int ResW   = 3 * 8 + 1;

    // Result queue after the pipeline; the pipeline never stalls.
    logic [ResW-1:0] r_q [QDepth];
    logic [QW-1:0]   r_wp, r_rp;
    logic [QW:0]     r_cnt;
    logic [QW:0]     inflight;
    logic [Pipe-1:0] r_pv;
    logic [ResW-1:0] r_out;
    logic            r_out_valid;
    logic            q_push, q_pop, pipe_in, pipe_out;
    logic [ResW-1:0] pipe_res;

    // Square root stage registers.
    sobel_pkg::t_root r_st [Steps+1][3];
    logic             r_last [Steps+1];

    // Squares of gradients, registered.
    function automatic logic [sobel_pkg::SqW-1:0] grad_sq(
        logic [2:0][2:0][sobel_pkg::PixW-1:0] w, int sh, logic gy_sel);
        sobel_pkg::t_grad g;
        logic signed [11:0] c [9];
        for (int k = 0; k < 9; k++) begin
            c[k] = 12'(w[k/3][k%3][sh +: 8]);
        end
        if (gy_sel) begin
            g = (c[6] + 2 * c[7] + c[8]) - (c[0] + 2 * c[1] + c[2]);
        end else begin
            g = (c[2] + 2 * c[5] + c[8]) - (c[0] + 2 * c[3] + c[6]);
        end
        return sobel_pkg::SqW'(g * g);
    endfunction

    logic [sobel_pkg::SqW-1:0] r_gx2 [3], r_gy2 [3];
    logic                      r_sq_last;

    assign pipe_in = i_job_valid;

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_gx2[ch] <= grad_sq(i_job.win, 16 - 8 * ch, 1'b0);
                r_gy2[ch] <= grad_sq(i_job.win, 16 - 8 * ch, 1'b1);
            end
            r_sq_last <= i_job.last;
        end
    end

    // Sum into the root pipeline entry.
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            r_st[0][ch].rem <= r_gx2[ch] + r_gy2[ch];
            r_st[0][ch].res <= '0;
        end
        r_last[0] <= r_sq_last;
    end

    // One result bit per stage, from one bit pair of the sum.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < Steps; s++) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_st[s+1][ch] <= sobel_pkg::root_step(r_st[s][ch],
                    (sobel_pkg::SqW+1)'(1) << (2 * (Steps - 1 - s)));
            end
            r_last[s+1] <= r_last[s];
        end
    end

    // Valid travels beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[Pipe-2:0], pipe_in};
        end
    end

    assign pipe_out = r_pv[Pipe-1];

    // Saturate each channel at 255.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            pipe_res[ResW-1-8*ch -: 8] =
                (r_st[Steps][ch].res > sobel_pkg::RootW'(255)) ? 8'hFF
                                                               : r_st[Steps][ch].res[7:0];
        end
        pipe_res[0] = r_last[Steps];
    end

    // Output register takes from the queue.
    assign q_pop  = (r_cnt != '0) && (!r_out_valid || !i_stall);
    assign q_push = pipe_out;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wp] <= pipe_res;
        end
        if (q_pop) begin
            r_out <= r_q[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (q_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QW+1)'(q_push) - (QW+1)'(q_pop);
            if (q_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Credits: words in pipeline plus queue must fit the queue.
    always_comb begin
        inflight = r_cnt + (QW+1)'($countones(r_pv));
    end

    assign o_job_room = (inflight + (QW+1)'(Slack)) < (QW+1)'(QDepth);

    assign o_valid         = r_out_valid;
    assign o_out_red       = r_out[24:17];
    assign o_out_green     = r_out[16:9];
    assign o_out_blue      = r_out[8:1];
    assign o_last_of_frame = r_out[0];

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Sobel RGB edge magnitude testbench
// Streams raster pixels through the block and compares each output word with
// a predictor that tracks the line stores, the 3x3 window and the raster
// position, across several frame sizes set over the config channel.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Watchdog = 20000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_edge_word;

    // Directed row: a pixel plus an optional typed-in expected word.
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         typed;
        t_edge_word word;
    } t_pixel_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        o_last_of_frame;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = sobel_pkg::CfgWidth;
    logic [12:0] i_cfg_data = '0;

    sobel_rgb_edge_magnitude DUT (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [sobel_pkg::PixW-1:0] upper_line [sobel_pkg::MaxWidth];
    logic [sobel_pkg::PixW-1:0] middle_line [sobel_pkg::MaxWidth];
    logic [sobel_pkg::PixW-1:0] win_px [9];
    int unsigned     frame_w, frame_h, col_pos, row_pos;

    t_edge_word edge_words [$];
    bit         typed_flag [$];
    t_edge_word typed_word [$];
    int         mismatches = 0;
    int         words_seen = 0;
    int         idle_cycles = 0;
    bit         timed_out = 1'b0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] chan_mag(int sh);
        int gx, gy, sq, r;
        gx = (int'(win_px[2][sh+:8]) + 2 * int'(win_px[5][sh+:8]) + int'(win_px[8][sh+:8]))
           - (int'(win_px[0][sh+:8]) + 2 * int'(win_px[3][sh+:8]) + int'(win_px[6][sh+:8]));
        gy = (int'(win_px[6][sh+:8]) + 2 * int'(win_px[7][sh+:8]) + int'(win_px[8][sh+:8]))
           - (int'(win_px[0][sh+:8]) + 2 * int'(win_px[1][sh+:8]) + int'(win_px[2][sh+:8]));
        sq = gx * gx + gy * gy;
        r = 0;
        while ((r + 1) * (r + 1) <= sq) r++;
        return (r > 255) ? 8'd255 : 8'(r);
    endfunction

    // Advance the predictor by one pixel and queue any resulting word.
    task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 bit typed, t_edge_word tw);
        int unsigned w, h, c;
        t_edge_word ew;
        w = clamp_dim(frame_w, sobel_pkg::MaxWidth);
        h = clamp_dim(frame_h, sobel_pkg::MaxHeight);
        c = col_pos % sobel_pkg::MaxWidth;
        for (int k = 0; k < 3; k++) begin
            win_px[k*3] = win_px[k*3+1];
            win_px[k*3+1] = win_px[k*3+2];
        end
        win_px[2] = upper_line[c];
        win_px[5] = middle_line[c];
        win_px[8] = {r, g, b};
        upper_line[c] = middle_line[c];
        middle_line[c] = {r, g, b};
        if (row_pos >= 2 && c >= 2) begin
            ew.red = chan_mag(16);
            ew.green = chan_mag(8);
            ew.blue = chan_mag(0);
            ew.last = (row_pos + 1 >= h && c + 1 >= w);
            edge_words.push_back(ew);
            typed_flag.push_back(typed);
            typed_word.push_back(tw);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Receiver: stalls on its own pattern, with quiet stretches.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 512 < 128) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Output check against the oldest expected word.
    always @(posedge i_clk) begin
        t_edge_word got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_out_red, o_out_green, o_out_blue, o_last_of_frame};
            words_seen++;
            if (edge_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected word %h", got);
            end else begin
                want = edge_words.pop_front();
                if (typed_flag.pop_front()) want = typed_word.pop_front();
                else void'(typed_word.pop_front());
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Word mismatch: expected r%0d g%0d b%0d l%0d, got r%0d g%0d b%0d l%0d",
                                 want.red, want.green, want.blue, want.last,
                                 got.red, got.green, got.blue, got.last);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= Watchdog) begin
            $display("Watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == sobel_pkg::CfgWidth) frame_w = val[10:0];
        else frame_h = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    // Wait until every expected word has come, then out the latency.
    task automatic drain();
        while (edge_words.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // Send one pixel; keeps valid high so bursts run back to back.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              bit typed, t_edge_word tw);
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (o_stall);
        predict_pixel(r, g, b, typed, tw);
    endtask

    int burst_left = 0;
    task automatic send_random(bit edgy);
        logic [7:0] r, g, b;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (edgy) begin
            r = ($urandom_range(0, 1) ? 8'hFF : 8'h00);
            g = ($urandom_range(0, 1) ? 8'hFF : 8'h00);
            b = 8'($urandom);
        end else begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
        send_pixel(r, g, b, 1'b0, '0);
    endtask

    t_pixel_row directed [$];
    t_pixel_row row;
    int         frame_sizes [5][2] = '{'{3, 3}, '{4, 5}, '{120, 3}, '{7, 4}, '{2, 2}};
    int         total_px = 0;

    initial begin
        frame_w = 640;
        frame_h = 480;
        col_pos = 0;
        row_pos = 0;
        foreach (win_px[k]) win_px[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a 3x3 frame first, vertical edge at full scale saturates.
        write_reg(sobel_pkg::CfgWidth, 13'd3);
        write_reg(sobel_pkg::CfgHeight, 13'd3);
        for (int k = 0; k < 9; k++) begin
            row.red = (k % 3 == 2) ? 8'hFF : 8'h00;
            row.green = 8'h00;
            row.blue = 8'hFF;
            row.typed = (k == 8);
            row.word = '{red: 8'd255, green: 8'd0, blue: 8'd0, last: 1'b1};
            directed.push_back(row);
        end
        // Then a flat 3x3 frame of all ones and two ramp rows, tracked by the predictor, that yield no word.
        for (int k = 0; k < 9; k++) begin
            row.red = 8'hFF;
            row.green = 8'hFF;
            row.blue = 8'hFF;
            row.typed = (k == 8);
            row.word = '{red: 8'd0, green: 8'd0, blue: 8'd0, last: 1'b1};
            directed.push_back(row);
        end
        for (int k = 0; k < 6; k++) begin
            row.red = 8'(k * 50);
            row.green = 8'(255 - k * 40);
            row.blue = 8'(k[0] ? 8'hAA : 8'h55);
            row.typed = 1'b0;
            directed.push_back(row);
        end
        foreach (directed[k])
            send_pixel(directed[k].red, directed[k].green, directed[k].blue,
                       directed[k].typed, directed[k].word);
        i_valid <= 1'b0;
        drain();

        // Random phases over several frame sizes, the smallest and one below range among them.
        for (int p = 0; p < 5; p++) begin
            write_reg(sobel_pkg::CfgWidth, 13'(frame_sizes[p][0]));
            write_reg(sobel_pkg::CfgHeight, 13'(frame_sizes[p][1]));
            for (int k = 0; k < ((p == 2) ? 3 * 120 : 120); k++) begin
                send_random(k % 3 == 0);
                total_px++;
            end
            i_valid <= 1'b0;
            drain();
        end
        // Register extremes: above range with full-width data bits, then a zero width.
        write_reg(sobel_pkg::CfgWidth, 13'h7FF);
        write_reg(sobel_pkg::CfgHeight, 13'h1FFF);
        write_reg(sobel_pkg::CfgWidth, 13'd0);
        write_reg(sobel_pkg::CfgHeight, 13'd3);
        for (int k = 0; k < 12; k++) send_random(1'b0);
        i_valid <= 1'b0;
        drain();

        $display("Covered %0d random pixels over frames from 2x2 (clamped) to 120x3,",
                 total_px);
        $display("with %0d output words checked under sender gaps and receiver stalls.",
                 words_seen);
        if (mismatches == 0 && edge_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
